// ===== design/avq_pkg.sv =====
// shared types, constants and helpers for the rotation quaternion step
package avq_pkg;

  // pipeline depths of the bit-per-stage units and the trig chain
  localparam int SQRT_STAGES = 32;
  localparam int TRIG_STAGES = 8;
  localparam int DIV_STAGES  = 31;
  // register stages outside the units: three in front, five before trig,
  // one before the divider and three behind it
  localparam int LATENCY = 3 + SQRT_STAGES + 5 + TRIG_STAGES + 1 + DIV_STAGES + 3;

  localparam logic [32:0] ONE_Q32       = 33'h1_0000_0000;
  localparam logic [31:0] HALF_Q32      = 32'h8000_0000;
  localparam logic [31:0] PI4_Q32       = 32'hC90F_DAA2;
  localparam logic [31:0] MIN_ANGLE_Q32 = 32'd4294967;

  // reciprocals ceil(2^36 / d), exact floor division for dividends below 2^30
  localparam logic [33:0] RCP_6  = 34'(((64'd1 << 36) + 64'd5) / 64'd6);
  localparam logic [33:0] RCP_12 = 34'(((64'd1 << 36) + 64'd11) / 64'd12);
  localparam logic [33:0] RCP_20 = 34'(((64'd1 << 36) + 64'd19) / 64'd20);
  localparam logic [33:0] RCP_30 = 34'(((64'd1 << 36) + 64'd29) / 64'd30);
  localparam logic [33:0] RCP_42 = 34'(((64'd1 << 36) + 64'd41) / 64'd42);
  localparam logic [33:0] RCP_48 = 34'(((64'd1 << 36) + 64'd47) / 64'd48);
  localparam logic [33:0] RCP_56 = 34'(((64'd1 << 36) + 64'd55) / 64'd56);

  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic [23:0]      ts;
  } front_t;

  typedef struct packed {
    front_t      fr;
    logic [31:0] angle;
    logic        limited;
    logic        small_ang;
    logic [30:0] s_small;
  } mid_t;

  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic             limited;
    logic             small_ang;
    logic [30:0]      s_small;
    logic [32:0]      cosv;
  } back_t;

  // floor(x / d) by reciprocal multiply
  function automatic logic [29:0] div_rcp(input logic [29:0] x, input logic [33:0] m);
    logic [63:0] p;
    p = {34'b0, x} * {30'b0, m};
    return {2'b0, p[63:36]};
  endfunction

  // floor(x * y / 2^32) where y is at most 2^32
  function automatic logic [29:0] mul_hi30(input logic [29:0] x, input logic [32:0] y);
    logic [62:0] p;
    p = {33'b0, x} * {30'b0, y};
    return p[61:32];
  endfunction

endpackage

// ===== design/avq_isqrt.sv =====
// pipelined integer square root, one result bit per stage
module avq_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [63:0]       in_radicand,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [31:0]       out_root,
  output logic [SIDE_W-1:0] out_side
);
  import avq_pkg::*;

  logic              valid_r [SQRT_STAGES];
  logic [33:0]       rem_r   [SQRT_STAGES];
  logic [31:0]       root_r  [SQRT_STAGES];
  logic [63:0]       rad_r   [SQRT_STAGES];
  logic [SIDE_W-1:0] side_r  [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic              pv;
    logic [33:0]       prem;
    logic [31:0]       proot;
    logic [63:0]       prad;
    logic [SIDE_W-1:0] pside;
    logic [35:0]       acc;
    logic [35:0]       trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = '0;
      assign proot = '0;
      assign prad  = in_radicand;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = valid_r[k-1];
      assign prem  = rem_r[k-1];
      assign proot = root_r[k-1];
      assign prad  = rad_r[k-1];
      assign pside = side_r[k-1];
    end

    assign acc   = {prem, prad[63:62]};
    assign trial = {2'b0, proot, 2'b01};
    assign ge    = acc >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else begin
        valid_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? 34'(acc - trial) : acc[33:0];
      root_r[k] <= {proot[30:0], ge};
      rad_r[k]  <= {prad[61:0], 2'b00};
      side_r[k] <= pside;
    end
  end

  assign out_valid = valid_r[SQRT_STAGES-1];
  assign out_root  = root_r[SQRT_STAGES-1];
  assign out_side  = side_r[SQRT_STAGES-1];

endmodule

// ===== design/avq_trig.sv =====
// sine and cosine of the half angle by truncated horner chains
module avq_trig #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [30:0]       in_h,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [31:0]       out_sin,
  output logic [32:0]       out_cos,
  output logic [SIDE_W-1:0] out_side
);
  import avq_pkg::*;

  logic              valid_r [TRIG_STAGES];
  logic [SIDE_W-1:0] side_r  [TRIG_STAGES];

  logic [30:0] h1_r, h2_r, h3_r, h4_r, h5_r, h6_r;
  logic [29:0] sq1_r, sq2_r, sq3_r, sq4_r, sq5_r, sq6_r;
  logic [29:0] qs2_r, qc2_r, ps3_r, pc3_r, qs4_r, qc4_r;
  logic [29:0] ps5_r, pc5_r, qs6_r, qc6_r, pc7_r;
  logic [31:0] sn7_r, sn8_r;
  logic [32:0] c8_r;
  logic [61:0] hh;
  logic [63:0] hs;

  assign hh = {31'b0, in_h} * {31'b0, in_h};
  assign hs = {33'b0, h6_r} * {31'b0, ONE_Q32 - {3'b0, qs6_r}};

  for (genvar k = 0; k < TRIG_STAGES; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else begin
        valid_r[k] <= (k == 0) ? in_valid : valid_r[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      side_r[k] <= (k == 0) ? in_side : side_r[(k == 0) ? 0 : k-1];
    end
  end

  always_ff @(posedge clk) begin
    // h^2
    h1_r  <= in_h;
    sq1_r <= hh[61:32];
    // first terms
    h2_r  <= h1_r;
    sq2_r <= sq1_r;
    qs2_r <= div_rcp(sq1_r, RCP_42);
    qc2_r <= div_rcp(sq1_r, RCP_56);
    h3_r  <= h2_r;
    sq3_r <= sq2_r;
    ps3_r <= mul_hi30(sq2_r, ONE_Q32 - {3'b0, qs2_r});
    pc3_r <= mul_hi30(sq2_r, ONE_Q32 - {3'b0, qc2_r});
    h4_r  <= h3_r;
    sq4_r <= sq3_r;
    qs4_r <= div_rcp(ps3_r, RCP_20);
    qc4_r <= div_rcp(pc3_r, RCP_30);
    h5_r  <= h4_r;
    sq5_r <= sq4_r;
    ps5_r <= mul_hi30(sq4_r, ONE_Q32 - {3'b0, qs4_r});
    pc5_r <= mul_hi30(sq4_r, ONE_Q32 - {3'b0, qc4_r});
    h6_r  <= h5_r;
    sq6_r <= sq5_r;
    qs6_r <= div_rcp(ps5_r, RCP_6);
    qc6_r <= div_rcp(pc5_r, RCP_12);
    // final sine product, last cosine product
    sn7_r <= hs[63:32];
    pc7_r <= mul_hi30(sq6_r, ONE_Q32 - {3'b0, qc6_r});
    sn8_r <= sn7_r;
    c8_r  <= ONE_Q32 - {4'b0, pc7_r[29:1]};
  end

  assign out_valid = valid_r[TRIG_STAGES-1];
  assign out_sin   = sn8_r;
  assign out_cos   = c8_r;
  assign out_side  = side_r[TRIG_STAGES-1];

endmodule

// ===== design/avq_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module avq_div #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [63:0]       in_num,
  input  logic [31:0]       in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [30:0]       out_quot,
  output logic [SIDE_W-1:0] out_side
);
  import avq_pkg::*;

  logic              valid_r [DIV_STAGES];
  logic [31:0]       rem_r   [DIV_STAGES];
  logic [30:0]       lo_r    [DIV_STAGES];
  logic [30:0]       quot_r  [DIV_STAGES];
  logic [31:0]       den_r   [DIV_STAGES];
  logic [SIDE_W-1:0] side_r  [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic              pv;
    logic [31:0]       prem;
    logic [30:0]       plo;
    logic [30:0]       pquot;
    logic [31:0]       pden;
    logic [SIDE_W-1:0] pside;
    logic [32:0]       t;
    logic              ge;

    if (k == 0) begin : g_first
      // quotient fits 31 bits, so the top of the dividend is below the divisor
      assign pv    = in_valid;
      assign prem  = in_num[62:31];
      assign plo   = in_num[30:0];
      assign pquot = '0;
      assign pden  = in_den;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = valid_r[k-1];
      assign prem  = rem_r[k-1];
      assign plo   = lo_r[k-1];
      assign pquot = quot_r[k-1];
      assign pden  = den_r[k-1];
      assign pside = side_r[k-1];
    end

    assign t  = {prem, plo[30]};
    assign ge = t >= {1'b0, pden};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else begin
        valid_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? 32'(t - {1'b0, pden}) : t[31:0];
      lo_r[k]   <= {plo[29:0], 1'b0};
      quot_r[k] <= {pquot[29:0], ge};
      den_r[k]  <= pden;
      side_r[k] <= pside;
    end
  end

  assign out_valid = valid_r[DIV_STAGES-1];
  assign out_quot  = quot_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];

endmodule

// ===== design/angular_velocity_to_rotation_quaternion.sv =====
// top level: rotation quaternion for one exponential-map integration step
//
// One input word is taken in every clock cycle (start high while busy is low)
// and its quaternion appears on the out_ ports for one cycle, marked by
// out_valid. The receiver cannot stall: the pipeline never holds, so
// results leave in input order at the rate they came in. busy is high
// only during reset and in the first cycle after it. The latency is set by the
// square root and the divider, which settle one result bit per register
// stage (32 and 31 stages), plus the eight-stage sine/cosine chain and the
// multiply stages around them. Angles above pi/4 clamp and raise
// out_angle_limited; vector parts then may saturate.
module angular_velocity_to_rotation_quaternion #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [31:0]           in_omega_x,
  input  logic signed [31:0]           in_omega_y,
  input  logic signed [31:0]           in_omega_z,
  input  logic        [23:0]           in_time_step,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_quat_w,
  output logic signed [DATA_WIDTH-1:0] out_quat_x,
  output logic signed [DATA_WIDTH-1:0] out_quat_y,
  output logic signed [DATA_WIDTH-1:0] out_quat_z,
  output logic                         out_angle_limited
);
  import avq_pkg::*;

  localparam int FRONT_W = $bits(front_t);
  localparam int MID_W   = $bits(mid_t);
  localparam int BACK_W  = $bits(back_t);
  localparam logic [64:0] SAT_MAX = (65'd1 << (DATA_WIDTH - 1)) - 65'd1;

  // saturate sign and magnitude into the output field
  function automatic logic [DATA_WIDTH-1:0] pack_sat(input logic neg, input logic [45:0] mag);
    logic [64:0] m;
    m = {19'b0, mag};
    if (neg) begin
      if (m > SAT_MAX + 65'd1) m = SAT_MAX + 65'd1;
      return DATA_WIDTH'(65'd0 - m);
    end
    if (m > SAT_MAX) m = SAT_MAX;
    return DATA_WIDTH'(m);
  endfunction

  logic busy_r;
  logic accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // ---- front: magnitudes, squares, sum of squares
  logic             v1_r, v2_r, v3_r;
  front_t           fr1_r, fr2_r, fr3_r;
  front_t           fr_in;
  logic [2:0][63:0] sq2_r;
  logic [63:0]      sum3_r;
  logic [2:0][31:0] om;

  assign om = {$unsigned(in_omega_z), $unsigned(in_omega_y), $unsigned(in_omega_x)};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fr_in.neg[i] = om[i][31];
      // most negative value gives 2^31, which still fits the magnitude
      fr_in.mag[i] = om[i][31] ? (32'd0 - om[i]) : om[i];
    end
    fr_in.ts = in_time_step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    fr1_r <= fr_in;
    fr2_r <= fr1_r;
    for (int i = 0; i < 3; i++) begin
      sq2_r[i] <= {32'b0, fr1_r.mag[i]} * {32'b0, fr1_r.mag[i]};
    end
    fr3_r  <= fr2_r;
    sum3_r <= sq2_r[0] + sq2_r[1] + sq2_r[2];
  end

  // ---- speed = floor(sqrt(sum))
  logic              v_sq;
  logic [31:0]       speed;
  logic [FRONT_W-1:0] fr_sq_bits;
  front_t            fr_sq;

  avq_isqrt #(.SIDE_W(FRONT_W)) u_isqrt (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (v3_r),
    .in_radicand (sum3_r),
    .in_side     (fr3_r),
    .out_valid   (v_sq),
    .out_root    (speed),
    .out_side    (fr_sq_bits)
  );
  assign fr_sq = fr_sq_bits;

  // ---- angle, clamp, small-angle scale
  logic        v4_r, v5_r, v6_r, v7_r, v8_r;
  front_t      fr4_r;
  logic [55:0] sp4_r;
  mid_t        mid5_r, mid6_r, mid7_r, mid8_r;
  mid_t        mid5_nxt, mid8_nxt;
  logic [29:0] a2_6_r;
  logic [31:0] f7_r;
  logic        lim5;
  logic [31:0] ang5;
  logic [63:0] ang_sq;
  logic [55:0] ts_f;

  assign lim5   = sp4_r[55:8] > {16'b0, PI4_Q32};
  assign ang5   = lim5 ? PI4_Q32 : sp4_r[39:8];
  assign ang_sq = {32'b0, mid5_r.angle} * {32'b0, mid5_r.angle};
  assign ts_f   = {32'b0, mid7_r.fr.ts} * {24'b0, f7_r};

  always_comb begin
    mid5_nxt           = '0;
    mid5_nxt.fr        = fr4_r;
    mid5_nxt.angle     = ang5;
    mid5_nxt.limited   = lim5;
    mid5_nxt.small_ang = ang5 < MIN_ANGLE_Q32;
    mid8_nxt           = mid7_r;
    mid8_nxt.s_small   = ts_f[54:24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      v4_r <= v_sq;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    fr4_r  <= fr_sq;
    sp4_r  <= {24'b0, speed} * {32'b0, fr_sq.ts};
    mid5_r <= mid5_nxt;
    // angle^2 only matters on the small-angle path, where it is tiny
    mid6_r <= mid5_r;
    a2_6_r <= ang_sq[61:32];
    mid7_r <= mid6_r;
    f7_r   <= HALF_Q32 - {2'b0, div_rcp(a2_6_r, RCP_48)};
    mid8_r <= mid8_nxt;
  end

  // ---- sin and cos of the half angle
  logic             v_tr;
  logic [31:0]      sn;
  logic [32:0]      cosv;
  logic [MID_W-1:0] mid_tr_bits;
  mid_t             mid_tr;

  avq_trig #(.SIDE_W(MID_W)) u_trig (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v8_r),
    .in_h      (mid8_r.angle[31:1]),
    .in_side   (mid8_r),
    .out_valid (v_tr),
    .out_sin   (sn),
    .out_cos   (cosv),
    .out_side  (mid_tr_bits)
  );
  assign mid_tr = mid_tr_bits;

  // ---- dividend sin * ts * 2^8, then divide by the angle
  logic        v9_r;
  logic [63:0] num9_r;
  logic [31:0] den9_r;
  back_t       back9_r;
  back_t       back9_nxt;
  logic [55:0] sn_ts;

  assign sn_ts = {24'b0, sn} * {32'b0, mid_tr.fr.ts};

  always_comb begin
    back9_nxt.mag       = mid_tr.fr.mag;
    back9_nxt.neg       = mid_tr.fr.neg;
    back9_nxt.limited   = mid_tr.limited;
    back9_nxt.small_ang = mid_tr.small_ang;
    back9_nxt.s_small   = mid_tr.s_small;
    back9_nxt.cosv      = cosv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else begin
      v9_r <= v_tr;
    end
  end

  always_ff @(posedge clk) begin
    num9_r  <= {sn_ts, 8'b0};
    den9_r  <= mid_tr.angle;
    back9_r <= back9_nxt;
  end

  logic              v_dv;
  logic [30:0]       quot;
  logic [BACK_W-1:0] back_dv_bits;
  back_t             back_dv;

  avq_div #(.SIDE_W(BACK_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v9_r),
    .in_num    (num9_r),
    .in_den    (den9_r),
    .in_side   (back9_r),
    .out_valid (v_dv),
    .out_quot  (quot),
    .out_side  (back_dv_bits)
  );
  assign back_dv = back_dv_bits;

  // ---- scale select, vector products, rounding and saturation
  logic             v10_r, v11_r, out_valid_r;
  logic [30:0]      s10_r;
  logic [30:0]      w10_r;
  back_t            back10_r;
  logic [2:0][62:0] p11_r;
  logic [30:0]      w11_r;
  logic [2:0]       neg11_r;
  logic             lim11_r;
  logic [33:0]      w_rnd;
  logic [DATA_WIDTH-1:0] qw_r, qx_r, qy_r, qz_r;
  logic             lim_r;
  logic [2:0][63:0] p_rnd;

  assign w_rnd = {1'b0, back_dv.cosv} + 34'd2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_rnd[i] = {1'b0, p11_r[i]} + 64'h2_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r       <= 1'b0;
      v11_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v10_r       <= v_dv;
      v11_r       <= v10_r;
      out_valid_r <= v11_r;
    end
  end

  always_ff @(posedge clk) begin
    s10_r    <= back_dv.small_ang ? back_dv.s_small : quot;
    w10_r    <= w_rnd[32:2];
    back10_r <= back_dv;
    for (int i = 0; i < 3; i++) begin
      p11_r[i] <= {31'b0, back10_r.mag[i]} * {32'b0, s10_r};
    end
    w11_r   <= w10_r;
    neg11_r <= back10_r.neg;
    lim11_r <= back10_r.limited;
    qw_r    <= pack_sat(1'b0, {15'b0, w11_r});
    qx_r    <= pack_sat(neg11_r[0], p_rnd[0][63:18]);
    qy_r    <= pack_sat(neg11_r[1], p_rnd[1][63:18]);
    qz_r    <= pack_sat(neg11_r[2], p_rnd[2][63:18]);
    lim_r   <= lim11_r;
  end

  assign out_valid         = out_valid_r;
  assign out_quat_w        = qw_r;
  assign out_quat_x        = qx_r;
  assign out_quat_y        = qy_r;
  assign out_quat_z        = qz_r;
  assign out_angle_limited = lim_r;

endmodule

// ===== design/avq_checker.sv =====
// port-level checks for the rotation quaternion block, bound to the top level
module avq_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic        [23:0]           in_time_step,
  input logic                         out_valid,
  input logic signed [DATA_WIDTH-1:0] out_quat_x,
  input logic signed [DATA_WIDTH-1:0] out_quat_y,
  input logic signed [DATA_WIDTH-1:0] out_quat_z,
  input logic                         out_angle_limited
);
  import avq_pkg::*;

  // every accepted word gives its result on out_valid
  a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted word produced no result");

  // no result without an earlier accepted word
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without an accepted word");

  // zero step gives no rotation axis and no clamp
  a_zero_step: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_time_step == 24'd0) |-> ##LATENCY
      (out_quat_x == '0 && out_quat_y == '0 && out_quat_z == '0 && !out_angle_limited))
    else $error("zero step gave a non-zero vector part");

  // busy only just after reset
  a_busy_reset: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> $past(!rst_n))
    else $error("busy outside the reset recovery cycle");

endmodule

bind angular_velocity_to_rotation_quaternion avq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_avq_checker (.*);

// ===== dv/angular_velocity_to_rotation_quaternion_tb.sv =====
// testbench for the rotation quaternion step: directed and random words against a predictor
module angular_velocity_to_rotation_quaternion_tb;

  localparam int DW = 32;
  // pipeline depth from the block's head; the final drain adds a margin to it
  localparam int PIPE_DEPTH = 83;

  // one expected quaternion
  typedef struct {
    logic [DW-1:0] w;
    logic [DW-1:0] x;
    logic [DW-1:0] y;
    logic [DW-1:0] z;
    logic          lim;
  } quat_t;

  int unsigned fail_count = 0;

  // prints one line per mismatch and counts it
  task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                 input logic [DW-1:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // bitwise integer square root of a 64-bit value
  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // saturate sign and magnitude into the output field
  function automatic logic [DW-1:0] clip_signed(input logic neg, input logic [63:0] mag);
    logic [63:0] top;
    top = (64'd1 << (DW - 1)) - 1;
    if (neg) begin
      if (mag > top + 1) mag = top + 1;
      return DW'(64'd0 - mag);
    end
    if (mag > top) mag = top;
    return DW'(mag);
  endfunction

  // quaternion for one integration step
  function automatic quat_t rotation_step(input logic [31:0] ox, input logic [31:0] oy,
                                          input logic [31:0] oz, input logic [23:0] ts_in);
    logic [63:0] mag[3];
    logic        neg[3];
    logic [31:0] om[3];
    logic [63:0] sum, spd, ang, h, h2, t, sn, c, s, a2, f, p, ts;
    logic        lim;
    quat_t       q;
    om[0] = ox; om[1] = oy; om[2] = oz;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = om[i][31];
      mag[i] = neg[i] ? (64'd1 << 32) - {32'd0, om[i]} : {32'd0, om[i]};
      sum += mag[i] * mag[i];
    end
    ts  = {40'd0, ts_in};
    spd = root_floor(sum);
    ang = (spd * ts) >> 8;
    lim = ang > 64'(avq_pkg::PI4_Q32);
    if (lim) ang = 64'(avq_pkg::PI4_Q32);
    h  = ang >> 1;
    h2 = (h * h) >> 32;
    t  = (64'd1 << 32) - h2 / 42;
    t  = (64'd1 << 32) - ((h2 * t) >> 32) / 20;
    t  = (64'd1 << 32) - ((h2 * t) >> 32) / 6;
    sn = (h * t) >> 32;
    c  = (64'd1 << 32) - h2 / 56;
    c  = (64'd1 << 32) - ((h2 * c) >> 32) / 30;
    c  = (64'd1 << 32) - ((h2 * c) >> 32) / 12;
    c  = (64'd1 << 32) - ((h2 * c) >> 32) / 2;
    if (ang < 64'(avq_pkg::MIN_ANGLE_Q32)) begin
      a2 = (ang * ang) >> 32;
      f  = (64'd1 << 31) - a2 / 48;
      s  = (ts * f) >> 24;
    end else begin
      s = ((sn * ts) << 8) / ang;
    end
    q.w = clip_signed(1'b0, (c + 2) >> 2);
    p = mag[0] * s; q.x = clip_signed(neg[0], (p + (64'd1 << 17)) >> 18);
    p = mag[1] * s; q.y = clip_signed(neg[1], (p + (64'd1 << 17)) >> 18);
    p = mag[2] * s; q.z = clip_signed(neg[2], (p + (64'd1 << 17)) >> 18);
    q.lim = lim;
    return q;
  endfunction

  // holds expected quaternions in issue order and checks the block's words
  class quat_scoreboard;
    quat_t pending[$];

    function void note_input(input logic [31:0] ox, input logic [31:0] oy,
                             input logic [31:0] oz, input logic [23:0] ts);
      pending.push_back(rotation_step(ox, oy, oz, ts));
    endfunction

    task check_result(input logic [DW-1:0] w, input logic [DW-1:0] x,
                      input logic [DW-1:0] y, input logic [DW-1:0] z, input logic lim);
      quat_t e;
      if (pending.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        fail_count++;
        return;
      end
      e = pending.pop_front();
      if (w !== e.w) report_mismatch("quat_w", w, e.w);
      if (x !== e.x) report_mismatch("quat_x", x, e.x);
      if (y !== e.y) report_mismatch("quat_y", y, e.y);
      if (z !== e.z) report_mismatch("quat_z", z, e.z);
      if (lim !== e.lim) report_mismatch("angle_limited", DW'(lim), DW'(e.lim));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic signed [31:0]   in_omega_x;
  logic signed [31:0]   in_omega_y;
  logic signed [31:0]   in_omega_z;
  logic        [23:0]   in_time_step;
  logic                 out_valid;
  logic signed [DW-1:0] out_quat_w;
  logic signed [DW-1:0] out_quat_x;
  logic signed [DW-1:0] out_quat_y;
  logic signed [DW-1:0] out_quat_z;
  logic                 out_angle_limited;

  quat_scoreboard sb = new();
  // when set the sender never idles
  bit no_gaps = 0;

  angular_velocity_to_rotation_quaternion #(.DATA_WIDTH(DW)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_omega_x(in_omega_x), .in_omega_y(in_omega_y), .in_omega_z(in_omega_z),
    .in_time_step(in_time_step), .out_valid(out_valid),
    .out_quat_w(out_quat_w), .out_quat_x(out_quat_x), .out_quat_y(out_quat_y),
    .out_quat_z(out_quat_z), .out_angle_limited(out_angle_limited)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // result side: the block cannot be stalled, so just check every strobed word
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      sb.check_result(out_quat_w, out_quat_x, out_quat_y, out_quat_z, out_angle_limited);
  end

  // present one word and hold it until the block takes it; start stays high
  // across back-to-back words and only drops for an idle cycle
  task automatic send_word(input logic [31:0] ox, input logic [31:0] oy,
                           input logic [31:0] oz, input logic [23:0] ts);
    while (!no_gaps && $urandom_range(99) < 11) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_omega_x   <= ox;
    in_omega_y   <= oy;
    in_omega_z   <= oz;
    in_time_step <= ts;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_input(ox, oy, oz, ts);
  endtask

  // drop start and wait until every expected word has come back
  task automatic drain_all();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // random velocity component with a spread of magnitudes
  function automatic logic [31:0] rand_omega();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000);
      2: return 32'($signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000);
      3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000);
    endcase
  endfunction

  function automatic logic [23:0] rand_step();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(255));
      2: return 24'($urandom_range(24'h00_4000));
      default: return $urandom_range(1) ? 24'hFF_FFFF : 24'd0;
    endcase
  endfunction

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_omega_x   = '0;
    in_omega_y   = '0;
    in_omega_z   = '0;
    in_time_step = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero step, zero velocity, tiny angle, clamping, most negative omega
    send_word(32'd0, 32'd0, 32'd0, 24'hFF_FFFF);
    send_word(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 24'd0);
    send_word(32'h0001_0000, 32'd0, 32'd0, 24'd1);
    send_word(32'h0000_0100, 32'h0000_0100, 32'hFFFF_FF00, 24'h00_1000);
    send_word(32'h0001_0000, 32'd0, 32'd0, 24'h00_4189);
    send_word(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 24'h80_0000);
    send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF);
    send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF);
    send_word(32'h8000_0000, 32'd0, 32'd0, 24'd1);
    send_word(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send_word(32'h0000_C90F, 32'd0, 32'd0, 24'hFF_FFFF);
    send_word(32'h0000_C910, 32'd0, 32'd0, 24'hFF_FFFF);
    send_word(32'h0064_0000, 32'hFF9C_0000, 32'd0, 24'h00_0100);
    send_word(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 24'h55_5555);
    send_word(32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0, 24'hAA_AAAA);

    // sender holds off until the pipeline has emptied
    drain_all();

    for (int n = 0; n < 1350; n++) begin
      no_gaps = (n >= 500 && n < 700);
      send_word(rand_omega(), rand_omega(), rand_omega(), rand_step());
      if (n == 900) drain_all();
    end

    drain_all();
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (fail_count == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/avq_pkg.sv
design/avq_isqrt.sv
design/avq_trig.sv
design/avq_div.sv
design/angular_velocity_to_rotation_quaternion.sv
design/avq_checker.sv
dv/angular_velocity_to_rotation_quaternion_tb.sv
